@@ rtl/lfk_pkg.sv @@
// Shared constants, types and helper functions for the leg forward kinematics block.
package lfk_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int TRIG_TABLE_LEN = 24;
   localparam int NUM_STAGES = (CORDIC_STAGES < TRIG_TABLE_LEN) ? CORDIC_STAGES : TRIG_TABLE_LEN;
   localparam int STAGE_IDX_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

   localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
   localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [35:0] GAIN_Q30 = 36'sd652032874;

   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] REG_THIGH_LENGTH = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CALF_LENGTH = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FOOT_OFFSET = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SIDE_FACTOR = 8'd3;
   localparam logic [15:0] SIDE_FACTOR_RESET = 16'h4000;

   typedef logic signed [35:0] q30_type;
   typedef logic signed [17:0] unit_type;

   typedef struct packed {
      q30_type x;
      q30_type y;
      q30_type z;
      logic flip;
   } rot_type;

   function automatic q30_type atan_entry(input logic [STAGE_IDX_W-1:0] i);
      q30_type r;
      r = '0;
      case (5'(i))
         5'd0: r = 36'sd843314857;
         5'd1: r = 36'sd497837829;
         5'd2: r = 36'sd263043837;
         5'd3: r = 36'sd133525159;
         5'd4: r = 36'sd67021687;
         5'd5: r = 36'sd33543516;
         5'd6: r = 36'sd16775851;
         5'd7: r = 36'sd8388437;
         5'd8: r = 36'sd4194283;
         5'd9: r = 36'sd2097149;
         5'd10: r = 36'sd1048576;
         5'd11: r = 36'sd524288;
         5'd12: r = 36'sd262144;
         5'd13: r = 36'sd131072;
         5'd14: r = 36'sd65536;
         5'd15: r = 36'sd32768;
         5'd16: r = 36'sd16384;
         5'd17: r = 36'sd8192;
         5'd18: r = 36'sd4096;
         5'd19: r = 36'sd2048;
         5'd20: r = 36'sd1024;
         5'd21: r = 36'sd512;
         5'd22: r = 36'sd256;
         5'd23: r = 36'sd128;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic unit_type to_unit(input q30_type v, input logic flip);
      logic signed [36:0] t;
      logic signed [22:0] r;
      unit_type u;
      t = 37'(v) + 37'sd8192;
      r = 23'(t >>> 14);
      if (r > 23'sd65536) u = 18'sd65536;
      else if (r < -23'sd65536) u = -18'sd65536;
      else u = 18'(r);
      if (flip) u = -u;
      return u;
   endfunction

endpackage

@@ rtl/lfk_cordic_cell.sv @@
// One CORDIC rotation cell for three angle lanes with its data stage and valid bit.
module lfk_cordic_cell (
   input  logic clock,
   input  logic reset,
   input  logic enable,
   input  logic [lfk_pkg::STAGE_IDX_W-1:0] stage_index,
   input  logic in_valid,
   input  lfk_pkg::rot_type in_rot [3],
   input  logic [95:0] in_side,
   output logic out_valid,
   output lfk_pkg::rot_type out_rot [3],
   output logic [95:0] out_side
);
   import lfk_pkg::*;

   q30_type atan_val;
   rot_type rot_in [3];
   rot_type rot_ff [3];
   logic [95:0] side_ff;
   logic valid_ff;

   assign atan_val = atan_entry(stage_index);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rot_in[k] = in_rot[k];
         if (!in_rot[k].z[35]) begin
            rot_in[k].x = in_rot[k].x - (in_rot[k].y >>> stage_index);
            rot_in[k].y = in_rot[k].y + (in_rot[k].x >>> stage_index);
            rot_in[k].z = in_rot[k].z - atan_val;
         end else begin
            rot_in[k].x = in_rot[k].x + (in_rot[k].y >>> stage_index);
            rot_in[k].y = in_rot[k].y - (in_rot[k].x >>> stage_index);
            rot_in[k].z = in_rot[k].z + atan_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         rot_ff <= rot_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rot = rot_ff;
   assign out_side = side_ff;

endmodule

@@ rtl/lfk_kinematics.sv @@
// Pipelined position and Jacobian-velocity arithmetic from sines and cosines.
module lfk_kinematics (
   input  logic clock,
   input  logic reset,
   input  logic enable,
   input  logic in_valid,
   input  lfk_pkg::unit_type s1,
   input  lfk_pkg::unit_type c1,
   input  lfk_pkg::unit_type s2,
   input  lfk_pkg::unit_type c2,
   input  lfk_pkg::unit_type s23,
   input  lfk_pkg::unit_type c23,
   input  logic signed [15:0] w1,
   input  logic signed [15:0] w2,
   input  logic signed [15:0] w3,
   input  logic [15:0] thigh_length,
   input  logic [15:0] calf_length,
   input  logic [15:0] foot_offset,
   input  logic signed [15:0] side_factor,
   output logic out_valid,
   output logic signed [17:0] pos_x,
   output logic signed [17:0] pos_y,
   output logic signed [17:0] pos_z,
   output logic signed [20:0] vel_x,
   output logic signed [20:0] vel_y,
   output logic signed [20:0] vel_z
);
   import lfk_pkg::*;

   function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
      logic signed [63:0] b;
      b = 64'sd1 <<< (s - 1);
      return (v + b) >>> s;
   endfunction

   function automatic logic signed [17:0] sat18(input logic signed [63:0] v);
      if (v > 64'sd131071) return 18'sd131071;
      if (v < -64'sd131072) return -18'sd131072;
      return 18'(v);
   endfunction

   function automatic logic signed [20:0] sat21(input logic signed [63:0] v);
      if (v > 64'sd1048575) return 21'sd1048575;
      if (v < -64'sd1048576) return -21'sd1048576;
      return 21'(v);
   endfunction

   logic [3:0] valid_ff;
   unit_type s1_a_ff, c1_a_ff;
   logic signed [15:0] w1_a_ff, w2_a_ff, w3_a_ff;
   logic signed [33:0] ld_a_ff;
   logic signed [35:0] ltc2_a_ff, lcs23_a_ff, lts2_a_ff, lcc23_a_ff;
   logic signed [63:0] ldc1_b_ff, lds1_b_ff, a_b_ff, g_b_ff, px_b_ff;
   unit_type s1_b_ff, c1_b_ff;
   logic signed [35:0] lcs23_b_ff, ltc2_b_ff;
   logic signed [15:0] w1_b_ff, w2_b_ff, w3_b_ff;
   logic signed [63:0] py_c_ff, pz_c_ff, px_c_ff;
   logic signed [63:0] j01_c_ff, j02_c_ff, j10_c_ff, j11_c_ff, j12_c_ff;
   logic signed [63:0] j20_c_ff, j21_c_ff, j22_c_ff;
   logic signed [15:0] w1_c_ff, w2_c_ff, w3_c_ff;
   logic signed [17:0] px_ff, py_ff, pz_ff;
   logic signed [20:0] vx_ff, vy_ff, vz_ff;
   logic signed [63:0] m_b, a_sum;

   assign a_sum = 64'(ltc2_a_ff) + 64'(lcs23_a_ff);
   assign m_b = 64'(lcs23_a_ff) + 64'(lts2_a_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
      if (enable) begin
         s1_a_ff <= s1;
         c1_a_ff <= c1;
         w1_a_ff <= w1;
         w2_a_ff <= w2;
         w3_a_ff <= w3;
         ld_a_ff <= 34'($signed({1'b0, foot_offset}) * side_factor);
         ltc2_a_ff <= 36'($signed({1'b0, thigh_length}) * c2);
         lcs23_a_ff <= 36'($signed({1'b0, calf_length}) * s23);
         lts2_a_ff <= 36'($signed({1'b0, thigh_length}) * s2);
         lcc23_a_ff <= 36'($signed({1'b0, calf_length}) * c23);

         ldc1_b_ff <= 64'(ld_a_ff * c1_a_ff) <<< 2;
         lds1_b_ff <= 64'(ld_a_ff * s1_a_ff) <<< 2;
         a_b_ff <= 64'(a_sum * c1_a_ff);
         g_b_ff <= 64'(m_b * c1_a_ff);
         px_b_ff <= 64'(lcc23_a_ff) - 64'(lts2_a_ff);
         s1_b_ff <= s1_a_ff;
         c1_b_ff <= c1_a_ff;
         lcs23_b_ff <= lcs23_a_ff;
         ltc2_b_ff <= ltc2_a_ff;
         w1_b_ff <= w1_a_ff;
         w2_b_ff <= w2_a_ff;
         w3_b_ff <= w3_a_ff;

         px_c_ff <= px_b_ff;
         py_c_ff <= -lds1_b_ff - a_b_ff;
         pz_c_ff <= ldc1_b_ff - 64'((64'(ltc2_b_ff) + 64'(lcs23_b_ff)) * s1_b_ff);
         j01_c_ff <= -64'(ltc2_b_ff) - 64'(lcs23_b_ff);
         j02_c_ff <= -64'(lcs23_b_ff);
         j10_c_ff <= rnd(-ldc1_b_ff + 64'((64'(ltc2_b_ff) + 64'(lcs23_b_ff)) * s1_b_ff), 16);
         j11_c_ff <= rnd(-g_b_ff, 16);
         j12_c_ff <= rnd(-64'(64'(lcs23_b_ff) * s1_b_ff), 16);
         j20_c_ff <= rnd(a_b_ff + lds1_b_ff, 16);
         j21_c_ff <= rnd(g_b_ff, 16);
         j22_c_ff <= rnd(64'(64'(lcs23_b_ff) * c1_b_ff), 16);
         w1_c_ff <= w1_b_ff;
         w2_c_ff <= w2_b_ff;
         w3_c_ff <= w3_b_ff;

         px_ff <= sat18(rnd(px_c_ff, 16));
         py_ff <= sat18(rnd(py_c_ff, 32));
         pz_ff <= sat18(rnd(pz_c_ff, 32));
         vx_ff <= sat21(rnd(j01_c_ff * w2_c_ff + j02_c_ff * w3_c_ff, 26));
         vy_ff <= sat21(rnd(j10_c_ff * w1_c_ff + j11_c_ff * w2_c_ff
                            + j12_c_ff * w3_c_ff, 26));
         vz_ff <= sat21(rnd(j20_c_ff * w1_c_ff + j21_c_ff * w2_c_ff
                            + j22_c_ff * w3_c_ff, 26));
      end
   end

   assign out_valid = valid_ff[3];
   assign pos_x = px_ff;
   assign pos_y = py_ff;
   assign pos_z = pz_ff;
   assign vel_x = vx_ff;
   assign vel_y = vy_ff;
   assign vel_z = vz_ff;

endmodule

@@ rtl/leg_forward_kinematics.sv @@
// Top level of the leg forward kinematics block: CORDIC cell chain, kinematics pipe, output stage.
//  Channel  Direction  Handshake              Contents
//  req_     in         req_valid/req_ready    joint angles and rates
//  rsp_     out        rsp_valid/rsp_ready    foot position and velocity
//  csr_     in         csr_valid/csr_ready    register index and write data
// One leg is accepted per cycle while the output register is empty or being taken.
// Legs pass angle reduction, CORDIC cells, trig conversion, kinematics stages and output.
// The whole pipeline advances only while the output register is empty or being taken.
// Reset clears all valid bits and loads register reset values.
module leg_forward_kinematics (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [15:0] req_hip_angle,
   input  logic signed [15:0] req_thigh_angle,
   input  logic signed [15:0] req_calf_angle,
   input  logic signed [15:0] req_hip_rate,
   input  logic signed [15:0] req_thigh_rate,
   input  logic signed [15:0] req_calf_rate,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [17:0] rsp_pos_x,
   output logic signed [17:0] rsp_pos_y,
   output logic signed [17:0] rsp_pos_z,
   output logic signed [20:0] rsp_vel_x,
   output logic signed [20:0] rsp_vel_y,
   output logic signed [20:0] rsp_vel_z,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [lfk_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0] csr_data
);
   import lfk_pkg::*;

   logic enable;
   logic [15:0] thigh_length_ff, calf_length_ff, foot_offset_ff, side_factor_ff;
   logic red_valid_ff;
   rot_type red_ff [3];
   logic [95:0] rates_ff;
   rot_type red_in [3];
   logic chain_valid [NUM_STAGES+1];
   rot_type chain_rot [NUM_STAGES+1][3];
   logic [95:0] chain_side [NUM_STAGES+1];
   logic trig_valid_ff;
   unit_type trig_ff [6];
   logic [47:0] trig_rates_ff;
   logic kin_valid;
   logic signed [17:0] kpx, kpy, kpz;
   logic signed [20:0] kvx, kvy, kvz;
   logic out_valid_ff;
   logic signed [17:0] px_ff, py_ff, pz_ff;
   logic signed [20:0] vx_ff, vy_ff, vz_ff;
   logic signed [16:0] ang [3];

   assign enable = !out_valid_ff || rsp_ready;
   assign req_ready = enable;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thigh_length_ff <= '0;
         calf_length_ff <= '0;
         foot_offset_ff <= '0;
         side_factor_ff <= SIDE_FACTOR_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_THIGH_LENGTH: thigh_length_ff <= csr_data[15:0];
            REG_CALF_LENGTH: calf_length_ff <= csr_data[15:0];
            REG_FOOT_OFFSET: foot_offset_ff <= csr_data[15:0];
            REG_SIDE_FACTOR: side_factor_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   assign ang[0] = 17'(req_hip_angle);
   assign ang[1] = 17'(req_thigh_angle);
   assign ang[2] = 17'(req_thigh_angle) + 17'(req_calf_angle);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         red_in[k].x = GAIN_Q30;
         red_in[k].y = '0;
         red_in[k].z = 36'(ang[k]) <<< 17;
         red_in[k].flip = 1'b0;
         for (int r = 0; r < 4; r++) begin
            if (red_in[k].z > HALF_PI_Q30) begin
               red_in[k].z = red_in[k].z - PI_Q30;
               red_in[k].flip = !red_in[k].flip;
            end else if (red_in[k].z < -HALF_PI_Q30) begin
               red_in[k].z = red_in[k].z + PI_Q30;
               red_in[k].flip = !red_in[k].flip;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_valid_ff <= 1'b0;
      end else if (enable) begin
         red_valid_ff <= req_valid;
      end
      if (enable) begin
         red_ff <= red_in;
         rates_ff <= {48'd0, req_hip_rate, req_thigh_rate, req_calf_rate};
      end
   end

   assign chain_valid[0] = red_valid_ff;
   assign chain_rot[0] = red_ff;
   assign chain_side[0] = rates_ff;

   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
      lfk_cordic_cell u_cell (
         .clock(clock),
         .reset(reset),
         .enable(enable),
         .stage_index(STAGE_IDX_W'(g)),
         .in_valid(chain_valid[g]),
         .in_rot(chain_rot[g]),
         .in_side(chain_side[g]),
         .out_valid(chain_valid[g+1]),
         .out_rot(chain_rot[g+1]),
         .out_side(chain_side[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_valid_ff <= 1'b0;
      end else if (enable) begin
         trig_valid_ff <= chain_valid[NUM_STAGES];
      end
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            trig_ff[2*k] <= to_unit(chain_rot[NUM_STAGES][k].y, chain_rot[NUM_STAGES][k].flip);
            trig_ff[2*k+1] <= to_unit(chain_rot[NUM_STAGES][k].x, chain_rot[NUM_STAGES][k].flip);
         end
         trig_rates_ff <= chain_side[NUM_STAGES][47:0];
      end
   end

   lfk_kinematics u_kin (
      .clock(clock),
      .reset(reset),
      .enable(enable),
      .in_valid(trig_valid_ff),
      .s1(trig_ff[0]),
      .c1(trig_ff[1]),
      .s2(trig_ff[2]),
      .c2(trig_ff[3]),
      .s23(trig_ff[4]),
      .c23(trig_ff[5]),
      .w1(trig_rates_ff[47:32]),
      .w2(trig_rates_ff[31:16]),
      .w3(trig_rates_ff[15:0]),
      .thigh_length(thigh_length_ff),
      .calf_length(calf_length_ff),
      .foot_offset(foot_offset_ff),
      .side_factor(side_factor_ff),
      .out_valid(kin_valid),
      .pos_x(kpx),
      .pos_y(kpy),
      .pos_z(kpz),
      .vel_x(kvx),
      .vel_y(kvy),
      .vel_z(kvz)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= kin_valid;
      end
      if (enable) begin
         px_ff <= kpx;
         py_ff <= kpy;
         pz_ff <= kpz;
         vx_ff <= kvx;
         vy_ff <= kvy;
         vz_ff <= kvz;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_pos_x = px_ff;
   assign rsp_pos_y = py_ff;
   assign rsp_pos_z = pz_ff;
   assign rsp_vel_x = vx_ff;
   assign rsp_vel_y = vy_ff;
   assign rsp_vel_z = vz_ff;

   property p_stall_holds;
      @(posedge clock) disable iff (reset) rsp_valid && !rsp_ready |=> rsp_valid;
   endproperty
   assert property (p_stall_holds) else $error("result dropped during stall");

   property p_ready_when_empty;
      @(posedge clock) disable iff (reset) !rsp_valid |-> req_ready;
   endproperty
   assert property (p_ready_when_empty) else $error("not ready with empty output");

   property p_out_from_kin;
      @(posedge clock) disable iff (reset) $rose(rsp_valid) |-> $past(kin_valid);
   endproperty
   assert property (p_out_from_kin) else $error("result without pipeline item");

endmodule
